/* hw/rtl/tgvg_pkg.sv */
// Shared types, sizes and codes for the text and graphics video generator.
package tgvg_pkg;

    localparam int VRAM_BYTES   = 2000;
    localparam int TEXT_COLUMNS = 40;
    localparam int TEXT_ROWS    = 25;
    localparam int GLYPH_BYTES  = 2048;
    localparam int GFX_W        = 160;
    localparam int GFX_H        = 100;

    localparam int VRAM_WORDS      = (VRAM_BYTES + 1) / 2;
    localparam int VRAM_AW         = $clog2(VRAM_WORDS);
    localparam int GLYPH_AW        = $clog2(GLYPH_BYTES);
    localparam int TEXT_CELL_LIMIT = VRAM_BYTES / 2;
    localparam int CALC_W          = 16;

    localparam logic [2:0] CMD_WRITE_VIDEO = 3'd0;
    localparam logic [2:0] CMD_WRITE_GLYPH = 3'd1;
    localparam logic [2:0] CMD_SET_MODE    = 3'd2;
    localparam logic [2:0] CMD_READ_MODE   = 3'd3;
    localparam logic [2:0] CMD_RENDER      = 3'd4;

    localparam logic [7:0] MODE_TEXT = 8'h00;
    localparam logic [7:0] MODE_GFX  = 8'h01;

    localparam logic [7:0] TEXT_ODD_FILL = 8'hF0;
    localparam logic [7:0] GFX_ODD_FILL  = 8'h00;
    localparam logic [7:0] EVEN_FILL     = 8'h00;
    localparam logic [3:0] GFX_ON        = 4'hF;
    localparam logic [3:0] GFX_OFF       = 4'h0;

    typedef struct packed {
        logic [2:0]  command;
        logic [10:0] address;
        logic [7:0]  data;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
    } cmd_t;

    typedef struct packed {
        logic [3:0] pixel_color;
        logic [7:0] read_value;
        logic       error_flag;
    } res_t;

endpackage

/* hw/rtl/text_graph_video_generator.sv */
// Two-mode video generator: video RAM, glyph store, mode bit and pixel render.
// Steps: command transfer, execute, finish, then result register for writes, mode read, errors
// and graphics render; text render adds a glyph step (video RAM read, then glyph read).
// Set mode: a clear pass runs before the result, one even/odd byte pair cleared per cycle.
// The single sequencer runs one command at a time; stall stays high until its result is issued.
// Reset: mode text, then a clear pass fills video RAM with 00,F0 pairs; stall held high.
module text_graph_video_generator
    import tgvg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_GLYPH  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [7:0] even_mem [VRAM_WORDS];
    logic [7:0] odd_mem [VRAM_WORDS];
    logic [7:0] glyph_mem [GLYPH_BYTES];

    logic [2:0]         state_reg, state_next;
    logic               mode_reg, mode_next;
    logic [VRAM_AW-1:0] clr_idx_reg, clr_idx_next;
    logic [7:0]         clr_fill_reg, clr_fill_next;
    logic               clr_reply_reg, clr_reply_next;
    cmd_t               item_reg;
    logic               ok_reg;
    logic               gbank_reg;
    logic [2:0]         gsel_reg;
    res_t               hold_reg, hold_next;
    logic               res_valid_reg, res_valid_next;
    res_t               res_reg, res_next;
    logic [7:0]         even_rd_reg, odd_rd_reg, glyph_rd_reg;

    logic              accept;
    logic [CALC_W-1:0] cell_num, gbit, gidx;
    logic              text_ok, gfx_ok;
    logic [VRAM_AW-1:0] rd_idx;

    logic               even_we, odd_we, glyph_we, glyph_re;
    logic [VRAM_AW-1:0] wr_idx;
    logic [7:0]         even_wdata, odd_wdata;
    logic [GLYPH_AW-1:0] glyph_addr;
    logic [7:0]         gfx_byte;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        cell_num = CALC_W'(cmd.pixel_y >> 3) * CALC_W'(TEXT_COLUMNS)
                 + CALC_W'(cmd.pixel_x >> 3);
        gbit = CALC_W'(cmd.pixel_y) * CALC_W'(GFX_W) + CALC_W'(cmd.pixel_x);
        gidx = gbit >> 3;
        text_ok = (CALC_W'(cmd.pixel_x) < CALC_W'(TEXT_COLUMNS * 8))
               && (CALC_W'(cmd.pixel_y) < CALC_W'(TEXT_ROWS * 8))
               && (cell_num < CALC_W'(TEXT_CELL_LIMIT));
        gfx_ok = (CALC_W'(cmd.pixel_x) < CALC_W'(GFX_W))
              && (CALC_W'(cmd.pixel_y) < CALC_W'(GFX_H))
              && (gidx < CALC_W'(VRAM_BYTES));
        rd_idx = mode_reg ? VRAM_AW'(gidx >> 1) : VRAM_AW'(cell_num);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            even_rd_reg <= even_mem[rd_idx];
            odd_rd_reg  <= odd_mem[rd_idx];
            item_reg    <= cmd;
            ok_reg      <= mode_reg ? gfx_ok : text_ok;
            gbank_reg   <= gidx[0];
            gsel_reg    <= gbit[2:0];
        end
        if (even_we)
        begin
            even_mem[wr_idx] <= even_wdata;
        end
        if (odd_we)
        begin
            odd_mem[wr_idx] <= odd_wdata;
        end
        if (glyph_we)
        begin
            glyph_mem[glyph_addr] <= item_reg.data;
        end
        if (glyph_re)
        begin
            glyph_rd_reg <= glyph_mem[glyph_addr];
        end
        hold_reg <= hold_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        clr_idx_next   = clr_idx_reg;
        clr_fill_next  = clr_fill_reg;
        clr_reply_next = clr_reply_reg;
        hold_next      = hold_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        even_we        = 1'b0;
        odd_we         = 1'b0;
        glyph_we       = 1'b0;
        glyph_re       = 1'b0;
        wr_idx         = clr_idx_reg;
        even_wdata     = EVEN_FILL;
        odd_wdata      = clr_fill_reg;
        glyph_addr     = GLYPH_AW'({even_rd_reg, item_reg.pixel_y[2:0]});
        gfx_byte       = gbank_reg ? odd_rd_reg : even_rd_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                even_we = 1'b1;
                odd_we  = 1'b1;
                if (clr_idx_reg == VRAM_AW'(VRAM_WORDS - 1))
                begin
                    state_next = clr_reply_reg ? ST_FINISH : ST_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                hold_next  = '0;
                state_next = ST_FINISH;
                case (item_reg.command)
                    CMD_WRITE_VIDEO:
                    begin
                        if (32'(item_reg.address) < VRAM_BYTES)
                        begin
                            wr_idx     = VRAM_AW'(item_reg.address >> 1);
                            even_wdata = item_reg.data;
                            odd_wdata  = item_reg.data;
                            even_we    = !item_reg.address[0];
                            odd_we     = item_reg.address[0];
                        end
                        else
                        begin
                            hold_next.error_flag = 1'b1;
                        end
                    end
                    CMD_WRITE_GLYPH:
                    begin
                        if (32'(item_reg.address) < GLYPH_BYTES)
                        begin
                            glyph_addr = GLYPH_AW'(item_reg.address);
                            glyph_we   = 1'b1;
                        end
                        else
                        begin
                            hold_next.error_flag = 1'b1;
                        end
                    end
                    CMD_SET_MODE:
                    begin
                        if (item_reg.data == MODE_TEXT || item_reg.data == MODE_GFX)
                        begin
                            mode_next      = item_reg.data[0];
                            clr_idx_next   = '0;
                            clr_fill_next  = (item_reg.data == MODE_TEXT) ? TEXT_ODD_FILL
                                                                          : GFX_ODD_FILL;
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        else
                        begin
                            hold_next.error_flag = 1'b1;
                        end
                    end
                    CMD_READ_MODE:
                    begin
                        hold_next.read_value = 8'(mode_reg);
                    end
                    CMD_RENDER:
                    begin
                        if (!ok_reg)
                        begin
                            hold_next.error_flag = 1'b1;
                        end
                        else if (!mode_reg)
                        begin
                            glyph_re   = 1'b1;
                            state_next = ST_GLYPH;
                        end
                        else
                        begin
                            hold_next.pixel_color = gfx_byte[3'd7 - gsel_reg] ? GFX_ON : GFX_OFF;
                        end
                    end
                    default:
                    begin
                        hold_next.error_flag = 1'b1;
                    end
                endcase
            end
            ST_GLYPH:
            begin
                hold_next.pixel_color = glyph_rd_reg[3'd7 - item_reg.pixel_x[2:0]]
                                      ? odd_rd_reg[7:4] : odd_rd_reg[3:0];
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next       = hold_reg;
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mode_reg      <= 1'b0;
            clr_idx_reg   <= '0;
            clr_fill_reg  <= TEXT_ODD_FILL;
            clr_reply_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            clr_idx_reg   <= clr_idx_next;
            clr_fill_reg  <= clr_fill_next;
            clr_reply_reg <= clr_reply_next;
            res_valid_reg <= res_valid_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_EXEC)
        else $error("transfer not followed by execute");

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> cmd_stall && clr_idx_reg < VRAM_AW'(VRAM_WORDS))
        else $error("clear pass open to commands or index out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside finish");

    a_render_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GLYPH |-> !mode_reg && ok_reg && item_reg.command == CMD_RENDER)
        else $error("glyph lookup without valid text render");

endmodule
